// File: rtl/isl_pkg.sv
// Shared types for the interval set logic unit.
// Holds the operation codes and the queue status bundle; no dependencies.
`default_nettype none

package isl_pkg;

  // Operation codes carried in the mode field.
  typedef enum logic [2:0] {
    MODE_INTERSECT = 3'd0,
    MODE_UNION     = 3'd1,
    MODE_DIFF      = 3'd2,
    MODE_PROPER    = 3'd3,
    MODE_SUBSET    = 3'd4,
    MODE_DISJOINT  = 3'd5
  } mode_t;

  // Fill status of the work queue, seen by both the front and the back.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

// File: rtl/interval_set_logic_unit.sv
// Interval set logic unit: intersection, union, difference and subset, proper-subset and disjoint tests.
// An accepted item passes the four-entry queue, then the output register once it is free.
// The queue takes one item per cycle while not full; an item with two results stays at
// its head until both are loaded. One result per cycle leaves while out_tready is high.
// Reset: synchronous active-low rst_n empties the queue and the output register.
`default_nettype none

module interval_set_logic_unit import isl_pkg::*; #(
  parameter int ENDPOINT_WIDTH = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  // mode, a_low, a_high, a_left_closed, a_right_closed,
  // b_low, b_high, b_left_closed, b_right_closed, zero fill
  input  wire logic [((4*ENDPOINT_WIDTH+7+7)/8)*8-1:0] in_tdata,
  output logic      out_tvalid,
  input  wire logic out_tready,
  // res_low, res_high, res_left_closed, res_right_closed, test_flag, zero fill
  output logic [((2*ENDPOINT_WIDTH+3+7)/8)*8-1:0] out_tdata,
  // no_interval
  output logic      out_tuser,
  output logic      out_tlast
);

  localparam int W       = ENDPOINT_WIDTH;
  localparam int ENTRY_W = 2 * (2 * W + 2) + 3;
  localparam int OUT_W   = ((2 * W + 3 + 7) / 8) * 8;
  localparam int OUT_PAD = OUT_W - (2 * W + 3);

  logic [ENTRY_W-1:0] wr_entry, rd_entry;
  logic               push, pop;
  q_stat_t            q_stat;
  logic [W-1:0]       res_low, res_high;
  logic               res_lc, res_rc, test_flag;

  isl_front #(.W(W)) u_front (
    .mode     (in_tdata[2:0]),
    .a_low    (in_tdata[3 +: W]),
    .a_high   (in_tdata[3+W +: W]),
    .a_lc     (in_tdata[3+2*W]),
    .a_rc     (in_tdata[4+2*W]),
    .b_low    (in_tdata[5+2*W +: W]),
    .b_high   (in_tdata[5+3*W +: W]),
    .b_lc     (in_tdata[5+4*W]),
    .b_rc     (in_tdata[6+4*W]),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .q_stat   (q_stat),
    .push     (push),
    .entry    (wr_entry)
  );

  isl_queue #(.WIDTH(ENTRY_W), .DEPTH(4)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (wr_entry),
    .pop     (pop),
    .rd_data (rd_entry),
    .stat    (q_stat)
  );

  isl_back #(.W(W)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .entry       (rd_entry),
    .q_stat      (q_stat),
    .pop         (pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .res_low     (res_low),
    .res_high    (res_high),
    .res_lc      (res_lc),
    .res_rc      (res_rc),
    .test_flag   (test_flag),
    .no_interval (out_tuser),
    .last        (out_tlast)
  );

  // Pack the result fields, lowest field first.
  assign out_tdata = {{OUT_PAD{1'b0}}, test_flag, res_rc, res_lc, res_high, res_low};

endmodule

`default_nettype wire

// File: rtl/isl_front.sv
// Front end: accepts an input item and classifies it into up to two results.
// Depends on isl_pkg for the operation codes and queue status.
`default_nettype none

module isl_front import isl_pkg::*; #(
  parameter int W = 32
) (
  input  wire logic [2:0]          mode,
  input  wire logic [W-1:0]        a_low,
  input  wire logic [W-1:0]        a_high,
  input  wire logic                a_lc,
  input  wire logic                a_rc,
  input  wire logic [W-1:0]        b_low,
  input  wire logic [W-1:0]        b_high,
  input  wire logic                b_lc,
  input  wire logic                b_rc,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire q_stat_t             q_stat,
  output logic                     push,
  // Fields from the lowest bit: result 0, result 1, none, flag, two results.
  output logic [2*(2*W+2)+2:0]     entry
);

  localparam int RES_W = 2 * W + 2;

  logic signed [W-1:0] alo, ahi, blo, bhi;
  logic lo_lt, lo_gt, lo_eq, hi_lt, hi_gt, hi_eq;
  logic ahi_lt_blo, ahi_eq_blo, alo_gt_bhi, alo_eq_bhi;
  logic ea, eb, apart, disj, sub, proper, left_kept, right_kept;
  logic [RES_W-1:0] res_a, res_b, res_isect, res_merge, res_lp, res_rp, r0, r1;
  logic two, flag, none;

  assign alo = $signed(a_low);
  assign ahi = $signed(a_high);
  assign blo = $signed(b_low);
  assign bhi = $signed(b_high);

  // Accept whenever the queue has room.
  assign in_ready = !q_stat.full;
  assign push     = in_valid && in_ready;

  // Endpoint comparisons shared by all operations.
  always_comb begin
    lo_lt      = alo < blo;
    lo_gt      = alo > blo;
    lo_eq      = alo == blo;
    hi_lt      = ahi < bhi;
    hi_gt      = ahi > bhi;
    hi_eq      = ahi == bhi;
    ahi_lt_blo = ahi < blo;
    ahi_eq_blo = ahi == blo;
    alo_gt_bhi = alo > bhi;
    alo_eq_bhi = alo == bhi;
    ea = (alo > ahi) || ((alo == ahi) && !(a_lc && a_rc));
    eb = (blo > bhi) || ((blo == bhi) && !(b_lc && b_rc));
  end

  // Relations between the two intervals.
  always_comb begin
    apart = ahi_lt_blo || (ahi_eq_blo && !a_rc && !b_lc) ||
            alo_gt_bhi || (alo_eq_bhi && !b_rc && !a_lc);
    disj  = ahi_lt_blo || (ahi_eq_blo && (!a_rc || !b_lc)) ||
            alo_gt_bhi || (alo_eq_bhi && (!a_lc || !b_rc));
    sub   = !lo_lt && !hi_gt && (b_lc || lo_gt || !a_lc) && (b_rc || hi_lt || !a_rc);
    proper = sub && (lo_gt || hi_lt || (lo_eq && (a_lc != b_lc)) ||
                     (hi_eq && (a_rc != b_rc)));
    left_kept  = lo_gt ? 1'b0 : (lo_lt || (!b_lc && a_lc));
    right_kept = hi_lt ? 1'b0 : (hi_gt || (!b_rc && a_rc));
  end

  // Candidate result intervals, packed as {rc, lc, high, low}.
  always_comb begin
    res_a = {a_rc, a_lc, a_high, a_low};
    res_b = {b_rc, b_lc, b_high, b_low};
    res_isect = {hi_gt ? b_rc : (hi_lt ? a_rc : (a_rc && b_rc)),
                 lo_lt ? b_lc : (lo_gt ? a_lc : (a_lc && b_lc)),
                 hi_lt ? a_high : b_high,
                 lo_gt ? a_low : b_low};
    res_merge = {hi_gt ? a_rc : (hi_lt ? b_rc : (a_rc || b_rc)),
                 lo_lt ? a_lc : (lo_gt ? b_lc : (a_lc || b_lc)),
                 hi_gt ? a_high : b_high,
                 lo_lt ? a_low : b_low};
    res_lp = {!b_lc, a_lc, b_low, a_low};
    res_rp = {a_rc, !b_rc, a_high, b_high};
  end

  // Select the results for the requested operation.
  always_comb begin
    r0   = '0;
    r1   = '0;
    two  = 1'b0;
    flag = 1'b0;
    none = 1'b1;
    unique case (mode_t'(mode))
      MODE_INTERSECT: begin
        r0   = res_isect;
        none = 1'b0;
      end
      MODE_UNION: begin
        none = 1'b0;
        if (ea) begin
          r0 = res_b;
        end else if (eb) begin
          r0 = res_a;
        end else if (!apart) begin
          r0 = res_merge;
        end else begin
          two = 1'b1;
          r0  = lo_gt ? res_b : res_a;
          r1  = lo_gt ? res_a : res_b;
        end
      end
      MODE_DIFF: begin
        if (ea) begin
          none = 1'b1;
        end else if (eb || disj) begin
          none = 1'b0;
          r0   = res_a;
        end else if (left_kept && right_kept) begin
          none = 1'b0;
          two  = 1'b1;
          r0   = res_lp;
          r1   = res_rp;
        end else if (left_kept) begin
          none = 1'b0;
          r0   = res_lp;
        end else if (right_kept) begin
          none = 1'b0;
          r0   = res_rp;
        end
      end
      MODE_PROPER:   flag = ea ? !eb : (!eb && proper);
      MODE_SUBSET:   flag = ea || (!eb && sub);
      MODE_DISJOINT: flag = ea || eb || disj;
      default:       flag = 1'b0;
    endcase
  end

  assign entry = {two, flag, none, r1, r0};

endmodule

`default_nettype wire

// File: rtl/isl_queue.sv
// Short work queue between the front and the back of the interval set unit.
// Depends on isl_pkg for the status bundle.
`default_nettype none

module isl_queue import isl_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rd_data,
  output q_stat_t               stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  assign stat.full  = (count_r == CW'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign rd_data    = mem_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// File: rtl/isl_back.sv
// Back end: turns queued work into one or two result items in an output register.
// Depends on isl_pkg for the queue status bundle.
`default_nettype none

module isl_back import isl_pkg::*; #(
  parameter int W = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [2*(2*W+2)+2:0] entry,
  input  wire q_stat_t              q_stat,
  output logic                      pop,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [W-1:0]              res_low,
  output logic [W-1:0]              res_high,
  output logic                      res_lc,
  output logic                      res_rc,
  output logic                      test_flag,
  output logic                      no_interval,
  output logic                      last
);

  localparam int RES_W = 2 * W + 2;

  logic [RES_W-1:0] r0, r1, res_r, res_nxt;
  logic             e_none, e_flag, e_two;
  logic             valid_r, phase_r, phase_nxt, load;
  logic             flag_r, none_r, last_r, flag_nxt, none_nxt, last_nxt;

  assign r0     = entry[RES_W-1:0];
  assign r1     = entry[2*RES_W-1:RES_W];
  assign e_none = entry[2*RES_W];
  assign e_flag = entry[2*RES_W+1];
  assign e_two  = entry[2*RES_W+2];

  // Load the output register when it is free or being drained and the queue is not empty.
  assign load = (!valid_r || out_ready) && !q_stat.empty;
  assign pop  = load && (phase_r || !e_two);

  always_comb begin
    phase_nxt = phase_r;
    if (load) begin
      phase_nxt = !phase_r && e_two;
    end
    res_nxt  = phase_r ? r1 : r0;
    flag_nxt = phase_r ? 1'b0 : e_flag;
    none_nxt = phase_r ? 1'b0 : e_none;
    last_nxt = phase_r || !e_two;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      if (load) begin
        valid_r <= 1'b1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (load) begin
      res_r  <= res_nxt;
      flag_r <= flag_nxt;
      none_r <= none_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_valid   = valid_r;
  assign res_low     = res_r[W-1:0];
  assign res_high    = res_r[2*W-1:W];
  assign res_lc      = res_r[2*W];
  assign res_rc      = res_r[2*W+1];
  assign test_flag   = flag_r;
  assign no_interval = none_r;
  assign last        = last_r;

endmodule

`default_nettype wire

// File: sim/testbench.sv
// Self-checking bench for interval_set_logic_unit: a directed table, then random items.
// Expected results come from a behavioral predictor in this file; depends on isl_pkg and the RTL.

module testbench;
  import isl_pkg::*;

  localparam int EW    = 32;
  localparam int IN_W  = ((4*EW+7+7)/8)*8;
  localparam int OUT_W = ((2*EW+3+7)/8)*8;
  localparam int RANDOM_ITEMS = 1825;
  localparam int PAUSE_AT     = 900;

  // Codes that the package leaves unnamed; the block must answer them with an empty item.
  localparam logic [2:0] MODE_SPARE6 = 3'd6;
  localparam logic [2:0] MODE_SPARE7 = 3'd7;

  typedef logic signed [EW-1:0] ep_t;

  localparam ep_t EP_MIN = {1'b1, {(EW-1){1'b0}}};
  localparam ep_t EP_MAX = {1'b0, {(EW-1){1'b1}}};

  typedef struct packed {
    ep_t lo;
    ep_t hi;
    bit  lc;
    bit  rc;
  } span_t;

  typedef struct packed {
    ep_t lo;
    ep_t hi;
    bit  lc;
    bit  rc;
    bit  flag;
    bit  none;
    bit  last;
  } outcome_t;

  typedef struct packed {
    logic [2:0] op;
    span_t      a;
    span_t      b;
    bit         typed;
    outcome_t   want;
  } stim_row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic             out_tuser;
  logic             out_tlast;

  outcome_t  expected_results[$];
  stim_row_t directed_rows[$];
  int        errors = 0;
  bit        steady_phase = 1'b0;

  interval_set_logic_unit #(.ENDPOINT_WIDTH(EW)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Free-running clock, period 10.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the block hangs.
  initial begin
    #10_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  // Append one expectation at the tail of the result queue.
  function automatic void expect_result(outcome_t o);
    expected_results.insert(expected_results.size(), o);
  endfunction

  // Append one row to the directed table.
  function automatic void add_row(stim_row_t r);
    directed_rows.insert(directed_rows.size(), r);
  endfunction

  function automatic span_t ivl(ep_t lo, ep_t hi, bit lc, bit rc);
    span_t s;
    s.lo = lo;
    s.hi = hi;
    s.lc = lc;
    s.rc = rc;
    return s;
  endfunction

  function automatic outcome_t piece(span_t x, bit last);
    outcome_t o;
    o = '0;
    o.lo = x.lo;
    o.hi = x.hi;
    o.lc = x.lc;
    o.rc = x.rc;
    o.last = last;
    return o;
  endfunction

  function automatic outcome_t answer(bit flag);
    outcome_t o;
    o = '0;
    o.flag = flag;
    o.none = 1'b1;
    o.last = 1'b1;
    return o;
  endfunction

  function automatic stim_row_t row(logic [2:0] op, span_t a, span_t b);
    stim_row_t r;
    r = '0;
    r.op = op;
    r.a = a;
    r.b = b;
    return r;
  endfunction

  function automatic stim_row_t row_known(logic [2:0] op, span_t a, span_t b, outcome_t want);
    stim_row_t r;
    r = row(op, a, b);
    r.typed = 1'b1;
    r.want = want;
    return r;
  endfunction

  // An interval is empty when its ends cross, or meet without both being closed.
  function automatic bit span_empty(span_t x);
    return x.lo > x.hi || (x.lo == x.hi && !(x.lc && x.rc));
  endfunction

  function automatic bit spans_disjoint(span_t a, span_t b);
    return a.hi < b.lo || (a.hi == b.lo && (!a.rc || !b.lc)) ||
           a.lo > b.hi || (a.lo == b.hi && (!a.lc || !b.rc));
  endfunction

  function automatic bit span_inside(span_t a, span_t b);
    return b.lo <= a.lo && b.hi >= a.hi &&
           (b.lc || a.lo > b.lo || !a.lc) &&
           (b.rc || a.hi < b.hi || !a.rc);
  endfunction

  // Work out the result items of one accepted item and queue them in order.
  function automatic void predict_results(logic [2:0] op, span_t a, span_t b);
    span_t m, lp, rp;
    bit    a_void, b_void, apart, left_kept, right_kept, flag;
    a_void = span_empty(a);
    b_void = span_empty(b);
    case (op)
      MODE_INTERSECT: begin
        m.lo = (a.lo > b.lo) ? a.lo : b.lo;
        m.hi = (a.hi < b.hi) ? a.hi : b.hi;
        m.lc = (a.lo < b.lo) ? b.lc : (a.lo > b.lo) ? a.lc : (a.lc && b.lc);
        m.rc = (a.hi > b.hi) ? b.rc : (a.hi < b.hi) ? a.rc : (a.rc && b.rc);
        expect_result(piece(m, 1'b1));
      end
      MODE_UNION: begin
        apart = a.hi < b.lo || (a.hi == b.lo && !a.rc && !b.lc) ||
                b.hi < a.lo || (b.hi == a.lo && !b.rc && !a.lc);
        if (a_void) begin
          expect_result(piece(b, 1'b1));
        end else if (b_void) begin
          expect_result(piece(a, 1'b1));
        end else if (!apart) begin
          m.lo = (a.lo < b.lo) ? a.lo : b.lo;
          m.hi = (a.hi > b.hi) ? a.hi : b.hi;
          m.lc = (a.lo < b.lo) ? a.lc : (b.lo < a.lo) ? b.lc : (a.lc || b.lc);
          m.rc = (a.hi > b.hi) ? a.rc : (b.hi > a.hi) ? b.rc : (a.rc || b.rc);
          expect_result(piece(m, 1'b1));
        end else if (a.lo <= b.lo) begin
          expect_result(piece(a, 1'b0));
          expect_result(piece(b, 1'b1));
        end else begin
          expect_result(piece(b, 1'b0));
          expect_result(piece(a, 1'b1));
        end
      end
      MODE_DIFF: begin
        // Pieces of A that stick out to the left and to the right of B.
        left_kept  = b.lo > a.lo || (b.lo == a.lo && !b.lc && a.lc);
        right_kept = b.hi < a.hi || (b.hi == a.hi && !b.rc && a.rc);
        lp = ivl(a.lo, b.lo, a.lc, !b.lc);
        rp = ivl(b.hi, a.hi, !b.rc, a.rc);
        if (a_void) begin
          expect_result(answer(1'b0));
        end else if (b_void || spans_disjoint(a, b)) begin
          expect_result(piece(a, 1'b1));
        end else if (left_kept && right_kept) begin
          expect_result(piece(lp, 1'b0));
          expect_result(piece(rp, 1'b1));
        end else if (left_kept) begin
          expect_result(piece(lp, 1'b1));
        end else if (right_kept) begin
          expect_result(piece(rp, 1'b1));
        end else begin
          expect_result(answer(1'b0));
        end
      end
      MODE_PROPER: begin
        if (a_void) flag = !b_void;
        else if (b_void) flag = 1'b0;
        else flag = span_inside(a, b) &&
                    (a.lo > b.lo || a.hi < b.hi ||
                     (a.lo == b.lo && a.lc != b.lc) ||
                     (a.hi == b.hi && a.rc != b.rc));
        expect_result(answer(flag));
      end
      MODE_SUBSET: begin
        if (a_void) flag = 1'b1;
        else if (b_void) flag = 1'b0;
        else flag = span_inside(a, b);
        expect_result(answer(flag));
      end
      MODE_DISJOINT: begin
        expect_result(answer(a_void || b_void || spans_disjoint(a, b)));
      end
      default: begin
        expect_result(answer(1'b0));
      end
    endcase
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Endpoints cluster around a center so that ties and touching ends are common.
  function automatic ep_t pick_point(ep_t center);
    case ($urandom_range(0, 15))
      0:       return EP_MIN;
      1:       return EP_MAX;
      2, 3:    return ep_t'($urandom);
      default: return center + ep_t'($urandom_range(0, 12)) - ep_t'(6);
    endcase
  endfunction

  function automatic span_t pick_span(ep_t center);
    span_t s;
    ep_t   t;
    s.lo = pick_point(center);
    s.hi = pick_point(center);
    s.lc = 1'($urandom_range(0, 1));
    s.rc = 1'($urandom_range(0, 1));
    // Most intervals are well formed; the rest stay crossed and thus empty.
    if (s.lo > s.hi && $urandom_range(0, 9) < 8) begin
      t = s.lo;
      s.lo = s.hi;
      s.hi = t;
    end
    return s;
  endfunction

  function automatic logic [IN_W-1:0] pack_item(logic [2:0] op, span_t a, span_t b);
    return IN_W'({b.rc, b.lc, b.hi, b.lo, a.rc, a.lc, a.hi, a.lo, op});
  endfunction

  // Offer one item, starting and ending at a falling edge.
  task automatic send_item(input logic [2:0] op, input span_t a, input span_t b,
                           input bit typed, input outcome_t want);
    int unsigned gap;
    gap = steady_phase ? 0 : pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  <= pack_item(op, a, b);
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (typed) expect_result(want);
    else predict_results(op, a, b);
    @(negedge clk);
  endtask

  // Drop valid and hold off until every queued result has come back.
  task automatic wait_until_drained();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (expected_results.size() != 0);
  endtask

  function automatic void compare_field(string name, longint want_v, longint got_v);
    if (want_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      errors++;
    end
  endfunction

  // Result side stalls at random, except during the steady stretches.
  int unsigned hold_left = 0;
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else begin
      out_tready <= 1'b1;
      hold_left  <= steady_phase ? 0 : pick_gap();
    end
  end

  // Compare each accepted result item with the oldest expectation.
  always @(posedge clk) begin
    outcome_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.lo   = out_tdata[EW-1:0];
      got.hi   = out_tdata[2*EW-1:EW];
      got.lc   = out_tdata[2*EW];
      got.rc   = out_tdata[2*EW+1];
      got.flag = out_tdata[2*EW+2];
      got.none = out_tuser;
      got.last = out_tlast;
      if (expected_results.size() == 0) begin
        $error("result item with nothing expected: low %0d high %0d", got.lo, got.hi);
        errors++;
      end else begin
        want = expected_results.pop_front();
        compare_field("res_low", want.lo, got.lo);
        compare_field("res_high", want.hi, got.hi);
        compare_field("res_left_closed", want.lc, got.lc);
        compare_field("res_right_closed", want.rc, got.rc);
        compare_field("test_flag", want.flag, got.flag);
        compare_field("no_interval", want.none, got.none);
        compare_field("last", want.last, got.last);
      end
    end
  end

  // Stimulus: directed table, then random items, then drain.
  initial begin
    logic [2:0] op;
    ep_t        center;
    span_t      a, b;

    // Directed cases; expectations typed in where they are plain to see.
    add_row(row_known(MODE_INTERSECT, ivl(EP_MIN, EP_MAX, 1, 1),
      ivl(EP_MIN, EP_MAX, 1, 1), piece(ivl(EP_MIN, EP_MAX, 1, 1), 1)));
    add_row(row(MODE_INTERSECT, ivl(1, 5, 1, 1), ivl(3, 9, 0, 1)));
    add_row(row(MODE_INTERSECT, ivl(0, 2, 1, 1), ivl(5, 7, 1, 1)));
    add_row(row(MODE_INTERSECT, ivl(3, 8, 1, 0), ivl(3, 8, 0, 1)));
    add_row(row_known(MODE_UNION, ivl(5, 5, 0, 0),
      ivl(EP_MIN, EP_MAX, 1, 1), piece(ivl(EP_MIN, EP_MAX, 1, 1), 1)));
    add_row(row_known(MODE_UNION, ivl(-3, 4, 1, 1), ivl(9, 2, 1, 1),
      piece(ivl(-3, 4, 1, 1), 1)));
    add_row(row(MODE_UNION, ivl(0, 4, 1, 1), ivl(4, 9, 0, 1)));
    add_row(row(MODE_UNION, ivl(0, 4, 1, 0), ivl(4, 9, 0, 1)));
    add_row(row(MODE_UNION, ivl(20, 30, 1, 1), ivl(-10, -5, 0, 0)));
    add_row(row(MODE_UNION, ivl(1, 5, 0, 1), ivl(1, 7, 1, 0)));
    add_row(row_known(MODE_DIFF, ivl(EP_MAX, EP_MIN, 1, 1),
      ivl(0, 9, 1, 1), answer(0)));
    add_row(row_known(MODE_DIFF, ivl(2, 3, 1, 1),
      ivl(EP_MIN, EP_MAX, 1, 1), answer(0)));
    add_row(row_known(MODE_DIFF, ivl(EP_MIN, EP_MAX, 1, 1),
      ivl(1, 0, 1, 1), piece(ivl(EP_MIN, EP_MAX, 1, 1), 1)));
    add_row(row_known(MODE_DIFF, ivl(0, 10, 1, 1), ivl(20, 30, 1, 1),
      piece(ivl(0, 10, 1, 1), 1)));
    add_row(row(MODE_DIFF, ivl(0, 10, 1, 1), ivl(3, 6, 0, 0)));
    add_row(row(MODE_DIFF, ivl(0, 10, 1, 1), ivl(5, 20, 1, 1)));
    add_row(row(MODE_DIFF, ivl(0, 10, 1, 1), ivl(-5, 4, 1, 0)));
    add_row(row(MODE_DIFF, ivl(0, 10, 1, 1), ivl(0, 10, 0, 0)));
    add_row(row_known(MODE_PROPER, ivl(7, 7, 0, 0), ivl(0, 9, 1, 1),
      answer(1)));
    add_row(row_known(MODE_PROPER, ivl(-4, 4, 1, 0), ivl(-4, 4, 1, 0),
      answer(0)));
    add_row(row(MODE_PROPER, ivl(0, 5, 0, 1), ivl(0, 5, 1, 1)));
    add_row(row_known(MODE_SUBSET, ivl(0, 5, 1, 1), ivl(3, 3, 1, 0),
      answer(0)));
    add_row(row_known(MODE_SUBSET, ivl(3, 2, 1, 1), ivl(8, 1, 0, 0),
      answer(1)));
    add_row(row_known(MODE_DISJOINT, ivl(EP_MIN, EP_MAX, 1, 1),
      ivl(0, 0, 0, 1), answer(1)));
    add_row(row(MODE_DISJOINT, ivl(0, 4, 1, 1), ivl(4, 9, 1, 1)));
    add_row(row_known(MODE_SPARE6, ivl(1, 2, 1, 1), ivl(1, 2, 1, 1),
      answer(0)));
    add_row(row_known(MODE_SPARE7, ivl(EP_MAX, EP_MAX, 1, 1),
      ivl(EP_MIN, EP_MIN, 1, 1), answer(0)));

    // Hold reset, then release it at a falling edge.
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].op, directed_rows[i].a, directed_rows[i].b,
                directed_rows[i].typed, directed_rows[i].want);
    end
    wait_until_drained();

    // Random items; every fifth stretch of 150 runs with no idling on either side.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady_phase = ((n / 150) % 5) == 4;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: center = '0;
        4, 5, 6:    center = ep_t'($urandom);
        7:          center = EP_MAX - ep_t'(4);
        default:    center = EP_MIN + ep_t'(4);
      endcase
      if ($urandom_range(0, 59) == 0) begin
        op = ($urandom_range(0, 1) != 0) ? MODE_SPARE7 : MODE_SPARE6;
      end else begin
        op = 3'($urandom_range(0, 5));
      end
      a = pick_span(center);
      b = pick_span(center);
      send_item(op, a, b, 1'b0, '0);
      if (n == PAUSE_AT) wait_until_drained();
    end
    steady_phase = 1'b0;

    // Drain, then watch a little longer for stray result items.
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
